>>> src/qps_pkg.sv
// Shared types, constants and register codes of the quadrature position servo.
`timescale 1ns / 1ps
`default_nettype none

package qps_pkg;

    localparam int MAX_TARGETS_DEF = 10;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;
    localparam int IN_DW  = 56;
    localparam int OUT_DW = 56;

    localparam logic [2:0] CMD_EDGE_A  = 3'd0;
    localparam logic [2:0] CMD_EDGE_B  = 3'd1;
    localparam logic [2:0] CMD_TIME    = 3'd2;
    localparam logic [2:0] CMD_TRIGGER = 3'd3;
    localparam logic [2:0] CMD_LOAD    = 3'd4;

    localparam logic [2:0] REG_GAIN_NOW   = 3'd0;
    localparam logic [2:0] REG_GAIN_PREV  = 3'd1;
    localparam logic [2:0] REG_GAIN_PREV2 = 3'd2;
    localparam logic [2:0] REG_CPR        = 3'd3;
    localparam logic [2:0] REG_LOOP       = 3'd4;
    localparam logic [2:0] REG_HOLDOFF    = 3'd5;
    localparam logic [2:0] REG_TRIALS     = 3'd6;

    localparam logic signed [31:0] GAIN_NOW_RST   = 32'sd60377;
    localparam logic signed [31:0] GAIN_PREV_RST  = -32'sd84347;
    localparam logic signed [31:0] GAIN_PREV2_RST = 32'sd23969;
    localparam logic [15:0]        CPR_RST        = 16'd216;
    localparam logic [7:0]         LOOP_RST       = 8'd5;
    localparam logic [15:0]        HOLDOFF_RST    = 16'd500;
    localparam logic [3:0]         TRIALS_RST     = 4'd0;

    localparam logic [6:0] DUTY_MAX = 7'd100;

    typedef struct packed {
        logic signed [31:0] gain_now;
        logic signed [31:0] gain_prev;
        logic signed [31:0] gain_prev2;
        logic [15:0]        counts_per_rev;
        logic [7:0]         loop_period_ms;
        logic [15:0]        holdoff_ms;
        logic [3:0]         trial_count;
    } qps_cfg_t;

    typedef struct packed {
        logic signed [31:0] err;
        logic signed [47:0] acc;
        logic [6:0]         fwd;
        logic [6:0]         rev;
    } qps_pid_t;

endpackage

`default_nettype wire

>>> src/qps_cfg.sv
// APB configuration register file of the quadrature position servo.
`timescale 1ns / 1ps
`default_nettype none

module qps_cfg
    import qps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    input  wire logic              pready,
    output logic      [CFG_DW-1:0] prdata,
    output qps_cfg_t               cfg
);

    qps_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[CFG_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_now       <= GAIN_NOW_RST;
            cfg_reg.gain_prev      <= GAIN_PREV_RST;
            cfg_reg.gain_prev2     <= GAIN_PREV2_RST;
            cfg_reg.counts_per_rev <= CPR_RST;
            cfg_reg.loop_period_ms <= LOOP_RST;
            cfg_reg.holdoff_ms     <= HOLDOFF_RST;
            cfg_reg.trial_count    <= TRIALS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_GAIN_NOW:   cfg_reg.gain_now       <= pwdata;
                REG_GAIN_PREV:  cfg_reg.gain_prev      <= pwdata;
                REG_GAIN_PREV2: cfg_reg.gain_prev2     <= pwdata;
                REG_CPR:        cfg_reg.counts_per_rev <= pwdata[15:0];
                REG_LOOP:       cfg_reg.loop_period_ms <= pwdata[7:0];
                REG_HOLDOFF:    cfg_reg.holdoff_ms     <= pwdata[15:0];
                REG_TRIALS:     cfg_reg.trial_count    <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_GAIN_NOW:   prdata = cfg_reg.gain_now;
            REG_GAIN_PREV:  prdata = cfg_reg.gain_prev;
            REG_GAIN_PREV2: prdata = cfg_reg.gain_prev2;
            REG_CPR:        prdata = CFG_DW'(cfg_reg.counts_per_rev);
            REG_LOOP:       prdata = CFG_DW'(cfg_reg.loop_period_ms);
            REG_HOLDOFF:    prdata = CFG_DW'(cfg_reg.holdoff_ms);
            REG_TRIALS:     prdata = CFG_DW'(cfg_reg.trial_count);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/qps_pid.sv
// Velocity-form PID datapath: count error, three products, saturating accumulate, duty.
`timescale 1ns / 1ps
`default_nettype none

module qps_pid
    import qps_pkg::*;
(
    input  wire qps_cfg_t             cfg,
    input  wire logic signed [31:0]   ref_counts,
    input  wire logic        [31:0]   enc_count,
    input  wire logic signed [31:0]   err_last,
    input  wire logic signed [31:0]   err_prev2,
    input  wire logic signed [47:0]   acc,
    output qps_pid_t                  res
);

    logic signed [32:0] diff;
    logic signed [31:0] err;
    logic signed [63:0] prod_now;
    logic signed [63:0] prod_prev;
    logic signed [63:0] prod_prev2;
    logic signed [65:0] sum;
    logic signed [47:0] acc_new;
    logic        [48:0] neg_mag;
    logic        [30:0] pos_whole;
    logic        [32:0] neg_whole;
    logic        [6:0]  pos_duty;
    logic        [6:0]  neg_duty;

    assign diff = {ref_counts[31], ref_counts} - {enc_count[31], enc_count};

    always_comb
    begin
        if (diff[32] == diff[31])
            err = diff[31:0];
        else if (diff[32])
            err = {1'b1, 31'd0};
        else
            err = {1'b0, {31{1'b1}}};
    end

    assign prod_now   = cfg.gain_now * err;
    assign prod_prev  = cfg.gain_prev * err_last;
    assign prod_prev2 = cfg.gain_prev2 * err_prev2;

    assign sum = 66'(acc) + 66'(prod_now) + 66'(prod_prev) + 66'(prod_prev2);

    always_comb
    begin
        if ((&sum[65:47]) || !(|sum[65:47]))
            acc_new = sum[47:0];
        else if (sum[65])
            acc_new = {1'b1, 47'd0};
        else
            acc_new = {1'b0, {47{1'b1}}};
    end

    assign neg_mag   = 49'd0 - {acc_new[47], acc_new};
    assign pos_whole = acc_new[46:16];
    assign neg_whole = neg_mag[48:16];

    assign pos_duty = acc_new[47] ? 7'd0 :
                      (pos_whole > 31'(DUTY_MAX)) ? DUTY_MAX : pos_whole[6:0];
    assign neg_duty = !acc_new[47] ? 7'd0 :
                      (neg_whole > 33'(DUTY_MAX)) ? DUTY_MAX : neg_whole[6:0];

    always_comb
    begin
        res.err = err;
        res.acc = acc_new;
        if (!err[31] && (err != 32'sd0))
        begin
            res.fwd = pos_duty;
            res.rev = 7'd0;
        end
        else
        begin
            res.fwd = 7'd0;
            res.rev = neg_duty;
        end
    end

endmodule

`default_nettype wire

>>> src/quadrature_position_servo.sv
// Top level of the quadrature position servo: stream pipeline, servo state, target table.
//
// Requests enter on the s_ channel: tuser carries the command (encoder edge on A or B,
// time update, trigger pulse, target load), tdata its levels, time and target fields.
// Every accepted request produces exactly one result on the m_ channel with both
// drive duties, the encoder count, the active target index and the finished flag.
// Registers sit behind the APB port; write them only while no request is in flight.
// An accepted request is loaded into the input register; the state update runs as it
// moves into the result register, raising m_tvalid. Throughput is one request per cycle
// while results are taken; the update cycle holds the PID path of three 32x32 multiplies
// feeding a four-term 66-bit add with saturation, which bounds the clock.
// Reset clears the count, errors and accumulator, sets the target index to -1,
// loads register defaults and empties both pipeline registers. The target table is
// not cleared: a trigger must only reach entries that have been loaded.
// When m_tready is low the result holds; one more request is taken into the input
// register, after which s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_position_servo
    import qps_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [0] level_a, [1] level_b, [33:2] now_ms, [37:34] target_slot, [53:38] target_revs
    input  wire logic [IN_DW-1:0]  s_tdata,
    // [2:0] cmd
    input  wire logic [2:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [6:0] duty_forward, [13:7] duty_reverse, [45:14] position_count,
    // [50:46] trial_number, [51] finished
    output logic [OUT_DW-1:0]      m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int IDX_W  = $clog2(MAX_TARGETS + 1) + 1;
    localparam int TAB_AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    qps_cfg_t cfg;
    qps_pid_t pid;

    logic               in_valid_reg;
    logic [2:0]         in_cmd_reg;
    logic [IN_DW-1:0]   in_data_reg;
    logic               out_valid_reg;
    logic [OUT_DW-1:0]  out_data_reg;
    logic               advance;
    logic               fire;

    logic [31:0]              enc_count_reg,  enc_count_next;
    logic signed [31:0]       ref_counts_reg, ref_counts_next;
    logic signed [31:0]       err_last_reg,   err_last_next;
    logic signed [31:0]       err_prev2_reg,  err_prev2_next;
    logic signed [47:0]       acc_reg,        acc_next;
    logic signed [IDX_W-1:0]  trial_idx_reg,  trial_idx_next;
    logic [31:0]              last_ctl_reg,   last_ctl_next;
    logic [31:0]              last_pulse_reg, last_pulse_next;
    logic [6:0]               fwd_hold_reg,   fwd_hold_next;
    logic [6:0]               rev_hold_reg,   rev_hold_next;
    logic                     done_reg,       done_next;

    logic signed [15:0] target_mem [MAX_TARGETS];
    logic signed [15:0] tab_val_reg;

    logic               lvl_a;
    logic               lvl_b;
    logic [31:0]        now_ms;
    logic [3:0]         slot;
    logic signed [15:0] revs;
    logic signed [31:0] idx32;
    logic signed [31:0] nidx32;
    logic signed [31:0] lim32;
    logic signed [31:0] idx_next32;
    logic signed [31:0] idx_keep32;
    logic signed [31:0] rd_idx32;
    logic [31:0]        slot32;
    logic [TAB_AW-1:0]  rd_addr;
    logic [TAB_AW-1:0]  wr_addr;
    logic signed [32:0] tgt_prod;
    logic               load_en;

    assign pready = 1'b1;

    qps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    qps_pid u_pid (
        .cfg        (cfg),
        .ref_counts (ref_counts_reg),
        .enc_count  (enc_count_reg),
        .err_last   (err_last_reg),
        .err_prev2  (err_prev2_reg),
        .acc        (acc_reg),
        .res        (pid)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign lvl_a  = in_data_reg[0];
    assign lvl_b  = in_data_reg[1];
    assign now_ms = in_data_reg[33:2];
    assign slot   = in_data_reg[37:34];
    assign revs   = in_data_reg[53:38];

    assign idx32  = 32'(trial_idx_reg);
    assign nidx32 = idx32 + 32'sd1;
    assign lim32  = (32'(cfg.trial_count) < 32'(MAX_TARGETS)) ?
                    32'(cfg.trial_count) : 32'(MAX_TARGETS);

    assign tgt_prod = tab_val_reg * $signed({1'b0, cfg.counts_per_rev});

    assign slot32  = 32'(slot);
    assign wr_addr = slot32[TAB_AW-1:0];
    assign load_en = fire && (in_cmd_reg == CMD_LOAD) && (slot32 < 32'(MAX_TARGETS));

    always_comb
    begin
        enc_count_next  = enc_count_reg;
        ref_counts_next = ref_counts_reg;
        err_last_next   = err_last_reg;
        err_prev2_next  = err_prev2_reg;
        acc_next        = acc_reg;
        trial_idx_next  = trial_idx_reg;
        last_ctl_next   = last_ctl_reg;
        last_pulse_next = last_pulse_reg;
        fwd_hold_next   = fwd_hold_reg;
        rev_hold_next   = rev_hold_reg;
        done_next       = done_reg;
        unique case (in_cmd_reg)
            CMD_EDGE_A:
                enc_count_next = enc_count_reg + ((lvl_a != lvl_b) ? 32'd1 : '1);
            CMD_EDGE_B:
                enc_count_next = enc_count_reg + ((lvl_a == lvl_b) ? 32'd1 : '1);
            CMD_TIME:
            begin
                if (!done_reg && !trial_idx_reg[IDX_W-1])
                begin
                    if (idx32 >= lim32)
                    begin
                        done_next     = 1'b1;
                        fwd_hold_next = 7'd0;
                        rev_hold_next = 7'd0;
                    end
                    else if ((now_ms - last_ctl_reg) > 32'(cfg.loop_period_ms))
                    begin
                        acc_next       = pid.acc;
                        err_prev2_next = err_last_reg;
                        err_last_next  = pid.err;
                        fwd_hold_next  = pid.fwd;
                        rev_hold_next  = pid.rev;
                        last_ctl_next  = now_ms;
                    end
                end
            end
            CMD_TRIGGER:
            begin
                if (!done_reg && ((now_ms - last_pulse_reg) > 32'(cfg.holdoff_ms)))
                begin
                    trial_idx_next  = IDX_W'(nidx32);
                    last_pulse_next = now_ms;
                    last_ctl_next   = now_ms;
                    if ((nidx32 >= lim32) || (nidx32 >= 32'(MAX_TARGETS)))
                    begin
                        done_next     = 1'b1;
                        fwd_hold_next = 7'd0;
                        rev_hold_next = 7'd0;
                    end
                    else
                        ref_counts_next = tgt_prod[31:0];
                end
            end
            default: ;
        endcase
    end

    assign idx_next32 = 32'(trial_idx_next);

    // prefetch the entry that the next trigger will reach
    assign idx_keep32 = fire ? idx_next32 : idx32;
    assign rd_idx32   = idx_keep32 + 32'sd1;
    assign rd_addr    = rd_idx32[TAB_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            enc_count_reg  <= '0;
            ref_counts_reg <= '0;
            err_last_reg   <= '0;
            err_prev2_reg  <= '0;
            acc_reg        <= '0;
            trial_idx_reg  <= '1;
            last_ctl_reg   <= '0;
            last_pulse_reg <= '0;
            fwd_hold_reg   <= '0;
            rev_hold_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                enc_count_reg  <= enc_count_next;
                ref_counts_reg <= ref_counts_next;
                err_last_reg   <= err_last_next;
                err_prev2_reg  <= err_prev2_next;
                acc_reg        <= acc_next;
                trial_idx_reg  <= trial_idx_next;
                last_ctl_reg   <= last_ctl_next;
                last_pulse_reg <= last_pulse_next;
                fwd_hold_reg   <= fwd_hold_next;
                rev_hold_reg   <= rev_hold_next;
                done_reg       <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (fire)
            out_data_reg <= {4'd0, done_next, idx_next32[4:0], enc_count_next,
                             rev_hold_next, fwd_hold_next};
        if (load_en)
            target_mem[wr_addr] <= revs;
        if (load_en && (wr_addr == rd_addr))
            tab_val_reg <= revs;
        else
            tab_val_reg <= target_mem[rd_addr];
    end

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("finished flag dropped");

    a_done_drives_off: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (fwd_hold_reg == 7'd0) && (rev_hold_reg == 7'd0))
        else $error("drive active after run end");

    a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
        !((fwd_hold_reg != 7'd0) && (rev_hold_reg != 7'd0)))
        else $error("forward and reverse drive both active");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_hold_reg <= DUTY_MAX) && (rev_hold_reg <= DUTY_MAX))
        else $error("duty above limit");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

>>> verif/quadrature_position_servo_tb.sv
// Self-checking testbench for the quadrature position servo: stream requests against a scoreboard.
`timescale 1ns / 1ps

import qps_pkg::*;

typedef struct packed {
    logic [6:0]  duty_forward;
    logic [6:0]  duty_reverse;
    logic [31:0] position_count;
    logic [4:0]  trial_number;
    logic        finished;
} servo_status_t;

class servo_scoreboard;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic signed [31:0] gain_now;
    logic signed [31:0] gain_prev;
    logic signed [31:0] gain_prev2;
    logic [15:0]        counts_per_rev;
    logic [7:0]         loop_period_ms;
    logic [15:0]        holdoff_ms;
    logic [3:0]         trial_count;

    logic [31:0]        enc_count;
    logic signed [31:0] ref_counts;
    logic signed [31:0] err_last;
    logic signed [31:0] err_before_last;
    logic signed [47:0] drive_acc;
    int                 trial_idx;
    logic [31:0]        last_control_ms;
    logic [31:0]        last_pulse_ms;
    logic [6:0]         fwd_hold;
    logic [6:0]         rev_hold;
    bit                 run_done;
    logic signed [15:0] targets [MAX_TARGETS_DEF];

    servo_status_t      expected_status [$];
    int                 errors;

    function new();
        gain_now        = GAIN_NOW_RST;
        gain_prev       = GAIN_PREV_RST;
        gain_prev2      = GAIN_PREV2_RST;
        counts_per_rev  = CPR_RST;
        loop_period_ms  = LOOP_RST;
        holdoff_ms      = HOLDOFF_RST;
        trial_count     = TRIALS_RST;
        enc_count       = '0;
        ref_counts      = '0;
        err_last        = '0;
        err_before_last = '0;
        drive_acc       = '0;
        trial_idx       = -1;
        last_control_ms = '0;
        last_pulse_ms   = '0;
        fwd_hold        = '0;
        rev_hold        = '0;
        run_done        = 1'b0;
        errors          = 0;
        foreach (targets[i])
            targets[i] = '0;
    endfunction

    function void set_register(logic [2:0] index, logic [31:0] value);
        case (index)
            REG_GAIN_NOW:   gain_now       = value;
            REG_GAIN_PREV:  gain_prev      = value;
            REG_GAIN_PREV2: gain_prev2     = value;
            REG_CPR:        counts_per_rev = value[15:0];
            REG_LOOP:       loop_period_ms = value[7:0];
            REG_HOLDOFF:    holdoff_ms     = value[15:0];
            REG_TRIALS:     trial_count    = value[3:0];
            default:        ;
        endcase
    endfunction

    function int run_limit();
        return (trial_count < MAX_TARGETS_DEF) ? int'(trial_count) : MAX_TARGETS_DEF;
    endfunction

    function void finish_run();
        run_done = 1'b1;
        fwd_hold = '0;
        rev_hold = '0;
    endfunction

    function void update_drive();
        longint             diff;
        logic signed [31:0] err;
        logic signed [67:0] total;
        longint             whole;
        diff = longint'(ref_counts) - longint'($signed(enc_count));
        if (diff > 64'sd2147483647)
            err = 32'sh7FFF_FFFF;
        else if (diff < -64'sd2147483648)
            err = 32'sh8000_0000;
        else
            err = 32'(diff);
        total = drive_acc + gain_now * err + gain_prev * err_last + gain_prev2 * err_before_last;
        if (total > ACC_HI)
            total = ACC_HI;
        else if (total < ACC_LO)
            total = ACC_LO;
        drive_acc       = total[47:0];
        err_before_last = err_last;
        err_last        = err;
        whole = longint'(drive_acc) / 65536;
        // zero error falls to the reverse side
        if (err > 0) begin
            fwd_hold = (whole < 0) ? 7'd0 : ((whole > DUTY_MAX) ? DUTY_MAX : 7'(whole));
            rev_hold = '0;
        end else begin
            whole    = -whole;
            rev_hold = (whole < 0) ? 7'd0 : ((whole > DUTY_MAX) ? DUTY_MAX : 7'(whole));
            fwd_hold = '0;
        end
    endfunction

    function void note_request(logic [2:0] cmd, logic level_a, logic level_b,
                               logic [31:0] now_ms, logic [3:0] slot, logic signed [15:0] revs);
        servo_status_t status;
        case (cmd)
            CMD_EDGE_A: enc_count += (level_a != level_b) ? 32'd1 : 32'hFFFF_FFFF;
            CMD_EDGE_B: enc_count += (level_a == level_b) ? 32'd1 : 32'hFFFF_FFFF;
            CMD_TIME: begin
                if (!run_done && trial_idx > -1) begin
                    if (trial_idx >= run_limit())
                        finish_run();
                    else if (32'(now_ms - last_control_ms) > loop_period_ms) begin
                        update_drive();
                        last_control_ms = now_ms;
                    end
                end
            end
            CMD_TRIGGER: begin
                if (!run_done && 32'(now_ms - last_pulse_ms) > holdoff_ms) begin
                    trial_idx++;
                    last_pulse_ms   = now_ms;
                    last_control_ms = now_ms;
                    if (trial_idx >= run_limit())
                        finish_run();
                    else
                        ref_counts = targets[trial_idx] * $signed({1'b0, counts_per_rev});
                end
            end
            CMD_LOAD: begin
                if (slot < MAX_TARGETS_DEF)
                    targets[slot] = revs;
            end
            default: ;
        endcase
        status.duty_forward   = fwd_hold;
        status.duty_reverse   = rev_hold;
        status.position_count = enc_count;
        status.trial_number   = 5'(trial_idx);
        status.finished       = run_done;
        expected_status.push_back(status);
    endfunction

    function void check_result(logic [OUT_DW-1:0] word);
        servo_status_t got;
        servo_status_t want;
        got.duty_forward   = word[6:0];
        got.duty_reverse   = word[13:7];
        got.position_count = word[45:14];
        got.trial_number   = word[50:46];
        got.finished       = word[51];
        if (expected_status.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: fwd=%0d rev=%0d pos=%0d trial=%0d fin=%0d",
                         got.duty_forward, got.duty_reverse, $signed(got.position_count),
                         $signed(got.trial_number), got.finished);
            return;
        end
        want = expected_status.pop_front();
        if (got.duty_forward !== want.duty_forward || got.duty_reverse !== want.duty_reverse ||
            got.position_count !== want.position_count ||
            got.trial_number !== want.trial_number || got.finished !== want.finished) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: want fwd=%0d rev=%0d pos=%0d trial=%0d fin=%0d, got fwd=%0d rev=%0d pos=%0d trial=%0d fin=%0d",
                         want.duty_forward, want.duty_reverse, $signed(want.position_count),
                         $signed(want.trial_number), want.finished,
                         got.duty_forward, got.duty_reverse, $signed(got.position_count),
                         $signed(got.trial_number), got.finished);
        end
    endfunction
endclass

module quadrature_position_servo_tb;

    localparam int         STALL_LIMIT = 3000;
    localparam int         PHASE_ITEMS = 300;
    localparam int         LONG_HOLD   = 250;
    localparam logic [2:0] CMD_SPARE   = 3'd5;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata;
    logic [2:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    servo_scoreboard     servo_sb;
    int                  results_seen;
    logic [31:0]         ms_now;
    int                  burst_left;

    quadrature_position_servo dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        servo_sb.set_register(index, value);
        @(posedge clk);
    endtask

    task automatic program_servo(input logic [31:0] g_now, input logic [31:0] g_prev,
                                 input logic [31:0] g_prev2, input logic [15:0] cpr,
                                 input logic [7:0] loop_ms, input logic [15:0] holdoff);
        write_register(REG_GAIN_NOW, g_now);
        write_register(REG_GAIN_PREV, g_prev);
        write_register(REG_GAIN_PREV2, g_prev2);
        write_register(REG_CPR, {16'd0, cpr});
        write_register(REG_LOOP, {24'd0, loop_ms});
        write_register(REG_HOLDOFF, {16'd0, holdoff});
    endtask

    task automatic push_request(input logic [2:0] cmd, input logic level_a, input logic level_b,
                                input logic [31:0] now_ms, input logic [3:0] slot,
                                input logic [15:0] revs, input int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, revs, slot, now_ms, level_b, level_a};
        do @(posedge clk); while (!s_tready);
        servo_sb.note_request(cmd, level_a, level_b, now_ms, slot, revs);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (servo_sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_phase(input int count, input int trigger_budget);
        logic [2:0]  cmd;
        logic        level_a;
        logic        level_b;
        logic [31:0] now_ms;
        logic [3:0]  slot;
        logic [15:0] revs;
        int          pick;
        int          gap;
        repeat (count) begin
            level_a = 1'($urandom);
            level_b = 1'($urandom);
            now_ms  = $urandom;
            slot    = 4'($urandom);
            revs    = 16'($urandom);
            if ($urandom_range(0, 29) == 0)
                ms_now = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                cmd = pick[0] ? CMD_EDGE_B : CMD_EDGE_A;
            end else if (pick < 88 || (pick >= 92 && pick < 95 && trigger_budget == 0)) begin
                cmd = CMD_TIME;
                ms_now += $urandom_range(0, 2 * servo_sb.loop_period_ms + 2);
                now_ms = ms_now;
            end else if (pick < 92) begin
                cmd = CMD_LOAD;
                if ($urandom_range(0, 3) != 0)
                    slot = 4'($urandom_range(0, MAX_TARGETS_DEF - 1));
                if ($urandom_range(0, 1) != 0)
                    revs = 16'($urandom_range(0, 40)) - 16'd20;
            end else if (pick < 95) begin
                cmd = CMD_TRIGGER;
                trigger_budget--;
                ms_now += $urandom_range(0, 2 * servo_sb.holdoff_ms + 2);
                now_ms = ms_now;
            end else begin
                cmd = CMD_SPARE + 3'($urandom_range(0, 2));
            end
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                gap = 0;
            end
            push_request(cmd, level_a, level_b, now_ms, slot, revs, gap);
        end
    endtask

    // result side: own stall pattern plus one long hold-off
    initial
    begin
        int cyc;
        bit held;
        cyc  = 0;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            cyc++;
            if (!held && results_seen >= 600) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                case ((cyc / 64) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (cyc % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial
    begin
        results_seen = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                servo_sb.check_result(m_tdata);
                results_seen++;
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle = 0;
            else
                idle++;
        end
        $display("FAIL quadrature_position_servo");
        $finish;
    end

    initial
    begin
        logic [31:0] last_trial;
        servo_sb   = new();
        burst_left = 1;
        ms_now     = '0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tuser    <= '0;
        s_tdata    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(REG_TRIALS, 32'd10);

        // edges on both channels, every level pair
        for (int k = 0; k < 8; k++)
            push_request((k < 4) ? CMD_EDGE_A : CMD_EDGE_B, 1'(k), 1'(k >> 1), $urandom,
                         4'($urandom), 16'($urandom), $urandom_range(0, 1));
        // fill every slot before any trigger can read one; slot 0 stays zero
        push_request(CMD_LOAD, 1'b0, 1'b0, '0, 4'd0, 16'd0, $urandom_range(0, 1));
        push_request(CMD_LOAD, 1'b1, 1'b1, '1, 4'd1, 16'h7FFF, $urandom_range(0, 1));
        push_request(CMD_LOAD, 1'b0, 1'b1, '0, 4'd2, 16'h8000, $urandom_range(0, 1));
        for (int k = 3; k < MAX_TARGETS_DEF; k++)
            push_request(CMD_LOAD, 1'($urandom), 1'($urandom), $urandom, 4'(k),
                         16'($urandom_range(0, 10)) - 16'd5, $urandom_range(0, 1));
        // out-of-range slot and the spare codes change nothing
        push_request(CMD_LOAD, 1'b1, 1'b0, $urandom, 4'd15, 16'h1234, $urandom_range(0, 1));
        for (int k = 0; k < 3; k++)
            push_request(CMD_SPARE + 3'(k), 1'($urandom), 1'($urandom), $urandom,
                         4'($urandom), 16'($urandom), $urandom_range(0, 1));
        // time before the first trigger, a trigger inside the holdoff, then a real one
        push_request(CMD_TIME, 1'b0, 1'b0, 32'hFFFF_FFFF, 4'd0, 16'd0, $urandom_range(0, 1));
        push_request(CMD_TRIGGER, 1'b0, 1'b0, 32'd100, 4'd0, 16'd0, $urandom_range(0, 1));
        push_request(CMD_TRIGGER, 1'b0, 1'b0, 32'd501, 4'd0, 16'd0, $urandom_range(0, 1));
        // period boundary, then an update with zero error
        push_request(CMD_TIME, 1'b0, 1'b0, 32'd506, 4'd0, 16'd0, $urandom_range(0, 1));
        push_request(CMD_TIME, 1'b0, 1'b0, 32'd507, 4'd0, 16'd0, $urandom_range(0, 1));
        ms_now = 32'd507;
        settle_pipeline();

        program_servo(GAIN_NOW_RST, GAIN_PREV_RST, GAIN_PREV2_RST, CPR_RST, 8'd0, 16'd20);
        run_random_phase(PHASE_ITEMS, 2);
        settle_pipeline();

        program_servo(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 8'd255, 16'd0);
        run_random_phase(PHASE_ITEMS, 2);
        settle_pipeline();

        program_servo(32'($urandom_range(0, 400000)) - 32'd200000,
                      32'($urandom_range(0, 400000)) - 32'd200000,
                      32'($urandom_range(0, 400000)) - 32'd200000,
                      16'd65535, 8'($urandom_range(0, 255)), 16'd65535);
        run_random_phase(PHASE_ITEMS, 2);
        settle_pipeline();

        program_servo($urandom, $urandom, $urandom, 16'($urandom_range(1, 65535)),
                      8'($urandom_range(0, 20)), 16'($urandom_range(0, 1000)));
        run_random_phase(PHASE_ITEMS, 2);
        settle_pipeline();

        // end the run: either the next time update or the next accepted trigger
        last_trial = (servo_sb.trial_idx + 1 < MAX_TARGETS_DEF) ?
                     32'(servo_sb.trial_idx + 1) : 32'(MAX_TARGETS_DEF);
        write_register(REG_TRIALS, ($urandom_range(0, 1) != 0) ? 32'd0 : last_trial);
        program_servo(GAIN_NOW_RST, GAIN_PREV_RST, GAIN_PREV2_RST, CPR_RST, 8'd3, 16'd10);
        run_random_phase(PHASE_ITEMS, 6);
        settle_pipeline();

        if (servo_sb.errors == 0 && servo_sb.expected_status.size() == 0)
            $display("PASS quadrature_position_servo");
        else
            $display("FAIL quadrature_position_servo");
        $finish;
    end

endmodule
